// File: rtl/amd_pkg.sv
// ----------------------------------------------------------------------------
// amd_pkg
// Shared constants and helpers for the affine matrix decomposer.
// ----------------------------------------------------------------------------
package amd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W        = 32;
	localparam int TOL_W         = 16;
	localparam int ANG_BITS      = 30;
	localparam int CORDIC_STEPS  = 30;
	localparam int CORD_W        = 34;
	localparam int ZW            = 33;
	localparam int STEP_W        = 5;
	localparam int ANGX_W        = 19;
	localparam int ANGY_W        = 18;
	localparam int ANGZ_W        = 19;

	localparam logic [TOL_W-1:0]     TOL_RESET   = 16'd1;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

	// arctan(2^-i) at Q30
	function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				5'd0: r = 33'sd843314857;
				5'd1: r = 33'sd497837829;
				5'd2: r = 33'sd263043837;
				5'd3: r = 33'sd133525159;
				5'd4: r = 33'sd67021687;
				5'd5: r = 33'sd33543516;
				5'd6: r = 33'sd16775851;
				5'd7: r = 33'sd8388437;
				5'd8: r = 33'sd4194283;
				5'd9: r = 33'sd2097149;
				default: r = ZW'(64'd1 << (ANG_BITS - int'(i)));
			endcase
			atan_entry = r;
		end
	endfunction

	// magnitude of a 32-bit signed value
	function automatic logic [ELEM_W:0] abs33(input logic signed [ELEM_W-1:0] e);
		logic signed [ELEM_W:0] x;
		begin
			x = (ELEM_W+1)'(e);
			abs33 = x[ELEM_W] ? (ELEM_W+1)'(-x) : x;
		end
	endfunction

endpackage

// File: rtl/amd_if.sv
// ----------------------------------------------------------------------------
// amd_if
// Channel interfaces: matrix column in, decomposition result out.
// ----------------------------------------------------------------------------
interface amd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         column;
	logic signed [31:0] elem0;
	logic signed [31:0] elem1;
	logic signed [31:0] elem2;
	logic signed [31:0] elem3;
	modport source (output valid, column, elem0, elem1, elem2, elem3, input ready);
	modport sink   (input valid, column, elem0, elem1, elem2, elem3, output ready);
endinterface

interface amd_out_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic signed [31:0] trans_x;
	logic signed [31:0] trans_y;
	logic signed [31:0] trans_z;
	logic signed [18:0] angle_x;
	logic signed [17:0] angle_y;
	logic signed [18:0] angle_z;
	logic [31:0]        scale_x;
	logic [31:0]        scale_y;
	logic [31:0]        scale_z;
	modport source (output valid, ok, trans_x, trans_y, trans_z, angle_x, angle_y,
		angle_z, scale_x, scale_y, scale_z, input ready);
	modport sink   (input valid, ok, trans_x, trans_y, trans_z, angle_x, angle_y,
		angle_z, scale_x, scale_y, scale_z, output ready);
endinterface

// File: rtl/affine_matrix_decompose.sv
// ----------------------------------------------------------------------------
// affine_matrix_decompose
// Splits a column-major 4x4 fixed-point matrix into translation, Euler
// angles and scale.
// ----------------------------------------------------------------------------
// Columns arrive one per transaction; columns 0 to 2 are stored and give no
// result. Column 3 starts the decomposition: a rejected matrix (|w| below
// zero_tolerance) goes straight to the output state, otherwise three column
// lanes each run squaring, an integer root and a divide in parallel, then the
// shared CORDIC unit runs asin (an integer root, then a CORDIC pass) and one
// or two atan2 (one under gimbal lock) before the result is registered; the
// default element format is Q16.16.
// No column is taken while a decomposition is in flight; a finished
// result waits in the output register while the next columns load.
// ----------------------------------------------------------------------------
module affine_matrix_decompose import amd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [TOL_W-1:0] wr_data,
	amd_in_if.sink           matrix,
	amd_out_if.source        decomp
);

	localparam int NW = FRAC_BITS + 2;
	localparam int AW = FRAC_BITS + 3;
	localparam int RN = FRAC_BITS + 1;
	localparam logic [2*RN-1:0]   ONE2  = (2*RN)'(64'd1 << (2 * FRAC_BITS));
	localparam logic signed [NW-1:0] ONE_Q = NW'(64'd1 << FRAC_BITS);

	typedef enum logic [3:0] {
		S_IDLE, S_LANES, S_SQ, S_ARG, S_ROOT, S_ASIN, S_AX, S_AZ, S_OUT
	} state_t;

	state_t                   state_q;
	logic [TOL_W-1:0]         tol_q;
	logic signed [ELEM_W-1:0] ub_q [3][3];
	logic signed [ELEM_W-1:0] tx_q, ty_q, tz_q;
	logic                     ok_q;
	logic                     gimbal_q;
	logic                     in_acc;
	logic                     lane_start_q;
	logic [2:0]               lane_done;
	logic [ELEM_W-1:0]        len [3];
	logic signed [NW-1:0]     nv [3][3];
	logic signed [NW-1:0]     v_q;
	logic [2*RN-1:0]          sq_q;
	logic [2*RN-1:0]          rad_q;
	logic                     rt_start_q;
	logic                     rt_done;
	logic [RN-1:0]            rt_root;
	logic                     cd_start_q;
	logic                     cd_done;
	logic signed [NW-1:0]     cy_q, cx_q;
	logic signed [AW-1:0]     cd_angle;
	logic signed [AW-1:0]     ax_q, ay_q, az_q;
	logic                     dv_q;

	assign matrix.ready = (state_q == S_IDLE);
	assign in_acc       = matrix.valid && matrix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (wr_en)
			tol_q <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (in_acc && matrix.column != 2'd3) begin
			ub_q[matrix.column][0] <= matrix.elem0;
			ub_q[matrix.column][1] <= matrix.elem1;
			ub_q[matrix.column][2] <= matrix.elem2;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		amd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start_q),
			.e0     (ub_q[c][0]),
			.e1     (ub_q[c][1]),
			.e2     (ub_q[c][2]),
			.done   (lane_done[c]),
			.len    (len[c]),
			.n0     (nv[c][0]),
			.n1     (nv[c][1]),
			.n2     (nv[c][2])
		);
	end

	amd_isqrt #(.N(RN)) u_cos_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_start_q),
		.v      (rad_q),
		.root   (rt_root),
		.done   (rt_done)
	);

	amd_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start_q),
		.y_in   (cy_q),
		.x_in   (cx_q),
		.angle  (cd_angle),
		.done   (cd_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lane_start_q <= 1'b0;
			rt_start_q   <= 1'b0;
			cd_start_q   <= 1'b0;
			dv_q         <= 1'b0;
		end else begin
			lane_start_q <= 1'b0;
			rt_start_q   <= 1'b0;
			cd_start_q   <= 1'b0;
			if (dv_q && decomp.ready && state_q != S_OUT)
				dv_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && matrix.column == 2'd3) begin
						tx_q <= matrix.elem0;
						ty_q <= matrix.elem1;
						tz_q <= matrix.elem2;
						if (abs33(matrix.elem3) < {{(ELEM_W+1-TOL_W){1'b0}}, tol_q}) begin
							ok_q    <= 1'b0;
							state_q <= S_OUT;
						end else begin
							ok_q         <= 1'b1;
							lane_start_q <= 1'b1;
							state_q      <= S_LANES;
						end
					end
				end
				S_LANES: begin
					if (lane_done[0]) begin
						v_q      <= -nv[0][2];
						gimbal_q <= (nv[0][2] == ONE_Q) || (nv[0][2] == -ONE_Q);
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					sq_q    <= (2*RN)'(v_q * v_q);
					state_q <= S_ARG;
				end
				S_ARG: begin
					rad_q      <= (sq_q >= ONE2) ? '0 : ONE2 - sq_q;
					rt_start_q <= 1'b1;
					state_q    <= S_ROOT;
				end
				S_ROOT: begin
					if (rt_done) begin
						cy_q       <= v_q;
						cx_q       <= $signed({1'b0, rt_root});
						cd_start_q <= 1'b1;
						state_q    <= S_ASIN;
					end
				end
				S_ASIN: begin
					if (cd_done) begin
						ay_q <= cd_angle;
						if (gimbal_q) begin
							cy_q <= -nv[2][0];
							cx_q <= nv[1][1];
						end else begin
							cy_q <= nv[1][2];
							cx_q <= nv[2][2];
						end
						cd_start_q <= 1'b1;
						state_q    <= S_AX;
					end
				end
				S_AX: begin
					if (cd_done) begin
						ax_q <= cd_angle;
						if (gimbal_q) begin
							az_q    <= '0;
							state_q <= S_OUT;
						end else begin
							cy_q       <= nv[0][1];
							cx_q       <= nv[0][0];
							cd_start_q <= 1'b1;
							state_q    <= S_AZ;
						end
					end
				end
				S_AZ: begin
					if (cd_done) begin
						az_q    <= cd_angle;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!dv_q || decomp.ready) begin
						dv_q           <= 1'b1;
						decomp.ok      <= ok_q;
						decomp.trans_x <= ok_q ? tx_q : '0;
						decomp.trans_y <= ok_q ? ty_q : '0;
						decomp.trans_z <= ok_q ? tz_q : '0;
						decomp.angle_x <= ok_q ? ANGX_W'(ax_q) : '0;
						decomp.angle_y <= ok_q ? ANGY_W'(ay_q) : '0;
						decomp.angle_z <= ok_q ? ANGZ_W'(az_q) : '0;
						decomp.scale_x <= ok_q ? len[0] : '0;
						decomp.scale_y <= ok_q ? len[1] : '0;
						decomp.scale_z <= ok_q ? len[2] : '0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign decomp.valid = dv_q;

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (lane_done == 3'b111) && (state_q == S_LANES))
		else $error("lanes finished out of step");

	a_cordic_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cd_done |-> (state_q == S_ASIN) || (state_q == S_AX) || (state_q == S_AZ))
		else $error("cordic result with no consumer");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(decomp.valid && !decomp.ok) |->
			(decomp.scale_x == '0) && (decomp.angle_y == '0) && (decomp.trans_x == '0))
		else $error("rejected result carries data");

	a_gimbal_z: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AX && cd_done && gimbal_q) |=> (az_q == '0))
		else $error("gimbal case left angle_z set");

endmodule

// File: rtl/amd_isqrt.sv
// ----------------------------------------------------------------------------
// amd_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module amd_isqrt import amd_pkg::*; #(
	parameter int N = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*N-1:0] v,
	output logic [N-1:0]   root,
	output logic           done
);

	localparam int CW = $clog2(N + 1);

	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [2*N-1:0] v_q;
	logic [N+1:0]   rem_q;
	logic [N-1:0]   root_q;
	logic [N+3:0]   rem_sh;
	logic [N+3:0]   trial;

	assign rem_sh = {rem_q, v_q[2*N-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				v_q    <= v;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				v_q <= v_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= (N+2)'(rem_sh - trial);
					root_q <= {root_q[N-2:0], 1'b1};
				end else begin
					rem_q  <= (N+2)'(rem_sh);
					root_q <= {root_q[N-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/amd_lane.sv
// ----------------------------------------------------------------------------
// amd_lane
// One column lane: squared length, integer root, three normalizing dividers.
// ----------------------------------------------------------------------------
module amd_lane import amd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [ELEM_W-1:0]   e0,
	input  logic signed [ELEM_W-1:0]   e1,
	input  logic signed [ELEM_W-1:0]   e2,
	output logic                       done,
	output logic [ELEM_W-1:0]          len,
	output logic signed [FRAC_BITS+1:0] n0,
	output logic signed [FRAC_BITS+1:0] n1,
	output logic signed [FRAC_BITS+1:0] n2
);

	localparam int NW = FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 1;
	localparam int CW = $clog2(FRAC_BITS + 1);

	typedef enum logic [2:0] {L_IDLE, L_SQ, L_ROOT, L_DIV, L_FIN} lstate_t;

	lstate_t                  state_q;
	logic [1:0]               cnt_q;
	logic [CW-1:0]            dcnt_q;
	logic [2*ELEM_W-1:0]      prod_s1;
	logic [2*ELEM_W-1:0]      acc_q;
	logic                     rt_start_q;
	logic                     rt_done;
	logic [ELEM_W-1:0]        rt_root;
	logic [ELEM_W-1:0]        len_q;
	logic signed [ELEM_W-1:0] sel;
	logic signed [ELEM_W-1:0] ev [3];
	logic [ELEM_W:0]          r_q [3];
	logic [QW-1:0]            q_q [3];
	logic signed [NW-1:0]     n_q [3];

	assign ev[0] = e0;
	assign ev[1] = e1;
	assign ev[2] = e2;

	always_comb begin
		case (cnt_q)
			2'd0: sel = e0;
			2'd1: sel = e1;
			2'd2: sel = e2;
			default: sel = e0;
		endcase
	end

	amd_isqrt #(.N(ELEM_W)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_start_q),
		.v      (acc_q),
		.root   (rt_root),
		.done   (rt_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= L_IDLE;
			done       <= 1'b0;
			rt_start_q <= 1'b0;
			cnt_q      <= '0;
			dcnt_q     <= '0;
		end else begin
			done       <= 1'b0;
			rt_start_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					if (cnt_q != 2'd3)
						prod_s1 <= (2*ELEM_W)'(sel * sel);
					if (cnt_q != 2'd0)
						acc_q <= acc_q + prod_s1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						rt_start_q <= 1'b1;
						state_q    <= L_ROOT;
					end
				end
				L_ROOT: begin
					if (rt_done) begin
						len_q  <= rt_root;
						dcnt_q <= '0;
						for (int k = 0; k < 3; k++) begin
							r_q[k] <= abs33(ev[k]);
							q_q[k] <= '0;
						end
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					for (int k = 0; k < 3; k++) begin
						logic [ELEM_W+1:0] t;
						t = (dcnt_q == '0) ? {1'b0, r_q[k]} : {r_q[k], 1'b0};
						if (t >= {2'b00, len_q}) begin
							r_q[k] <= (ELEM_W+1)'(t - {2'b00, len_q});
							q_q[k] <= {q_q[k][QW-2:0], 1'b1};
						end else begin
							r_q[k] <= (ELEM_W+1)'(t);
							q_q[k] <= {q_q[k][QW-2:0], 1'b0};
						end
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == CW'(FRAC_BITS))
						state_q <= L_FIN;
				end
				L_FIN: begin
					for (int k = 0; k < 3; k++) begin
						if (len_q == '0)
							n_q[k] <= '0;
						else if (ev[k][ELEM_W-1])
							n_q[k] <= -$signed({1'b0, q_q[k]});
						else
							n_q[k] <= $signed({1'b0, q_q[k]});
					end
					done    <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign len = len_q;
	assign n0  = n_q[0];
	assign n1  = n_q[1];
	assign n2  = n_q[2];

endmodule

// File: rtl/amd_cordic.sv
// ----------------------------------------------------------------------------
// amd_cordic
// Vectoring CORDIC atan2 at Q30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module amd_cordic import amd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [FRAC_BITS+1:0] y_in,
	input  logic signed [FRAC_BITS+1:0] x_in,
	output logic signed [FRAC_BITS+2:0] angle,
	output logic                        done
);

	localparam int AW = FRAC_BITS + 3;
	localparam int SH = ANG_BITS - FRAC_BITS;

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

	cstate_t                  state_q;
	logic [STEP_W-1:0]        i_q;
	logic signed [CORD_W-1:0] x_q, y_q;
	logic signed [ZW-1:0]     z_q;
	logic                     zero_q;
	logic signed [CORD_W-1:0] xs, ys, dx, dy;
	logic [ZW-1:0]            mag;
	logic [ZW:0]              rnd;
	logic signed [AW-1:0]     res;

	assign xs  = CORD_W'(x_in) <<< SH;
	assign ys  = CORD_W'(y_in) <<< SH;
	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign mag = z_q[ZW-1] ? ZW'(-z_q) : ZW'(z_q);
	assign rnd = ({1'b0, mag} + (ZW+1)'(64'd1 << (SH - 1))) >> SH;
	assign res = z_q[ZW-1] ? -$signed(AW'(rnd)) : $signed(AW'(rnd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done    <= 1'b0;
			i_q     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						zero_q <= (x_in == '0) && (y_in == '0);
						i_q    <= '0;
						if (xs < 0) begin
							if (ys >= 0) begin
								x_q <= ys;
								y_q <= -xs;
								z_q <= HALF_PI_Q30;
							end else begin
								x_q <= -ys;
								y_q <= xs;
								z_q <= -HALF_PI_Q30;
							end
						end else begin
							x_q <= xs;
							y_q <= ys;
							z_q <= '0;
						end
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (y_q >= 0) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_entry(i_q);
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_entry(i_q);
					end
					i_q <= i_q + 1'b1;
					if (i_q == STEP_W'(CORDIC_STEPS - 1))
						state_q <= C_FIN;
				end
				C_FIN: begin
					angle   <= zero_q ? '0 : res;
					done    <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule
